[rtl/ymodem_receiver_assert.svh]
// Assertion macros used by the receiver core RTL.
`ifndef YMODEM_RECEIVER_ASSERT_SVH
`define YMODEM_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define YMR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ymodem receiver assertion failed");
`define YMR_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) cond |=> prop) \
      else $error("ymodem receiver assertion failed");
`else
`define YMR_ASSERT(label, prop)
`define YMR_ASSERT_NEXT(label, cond, prop)
`endif
`endif

[rtl/ymr_pkg.sv]
package ymr_pkg;

   localparam logic [7:0] BYTE_SOH = 8'h01;
   localparam logic [7:0] BYTE_STX = 8'h02;
   localparam logic [7:0] BYTE_EOT = 8'h04;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_CA  = 8'h18;
   localparam logic [7:0] BYTE_C   = 8'h43;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic CSR_SIZE_LIMIT  = 1'b0;
   localparam logic CSR_ERROR_LIMIT = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  reply_byte;
      logic        last_of_run;
      logic [1:0]  session_status;
      logic [31:0] size_bytes;
      logic        size_known;
   } rsp_type;

   // Up to two result beats produced by one accepted input beat.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

[rtl/ymr_core.sv]
module ymr_core
   import ymr_pkg::*;
#(
   parameter int SIZE_CHARS_MAX = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data,
   output push_type    push
);

   localparam int IW = $clog2(SIZE_CHARS_MAX + 1);
   localparam logic [10:0] SHORT_LEN = 11'd128;
   localparam logic [10:0] LONG_LEN  = 11'd1024;
   localparam logic [10:0] COUNT_MAX = 11'd2047;

   typedef enum logic [1:0] {
      ST_RUNNING, ST_DONE, ST_ABORTED, ST_OVERSIZE
   } phase_type;

   typedef enum logic [2:0] {
      K_NONE, K_SOH, K_STX, K_EOT, K_CA, K_ABT, K_OTHER
   } kind_type;

   typedef enum logic [2:0] {
      PM_START, PM_DEC, PM_ZERO, PM_HEX, PM_DONE, PM_BAD
   } pm_type;

   typedef enum logic [1:0] {
      HF_NAME, HF_SIZE, HF_REST
   } field_type;

   typedef struct packed {
      pm_type          mode;
      logic [IW-1:0]   idx;
      logic [31:0]     acc;
   } parse_type;

   function automatic parse_type size_feed(parse_type s, logic [7:0] c);
      parse_type  r;
      logic [3:0] d;
      logic       step;
      r    = s;
      d    = 4'd0;
      step = 1'b0;
      if (s.mode != PM_DONE && s.mode != PM_BAD) begin
         if (c == 8'h20 || c == 8'h00) begin
            r.mode = (s.mode == PM_HEX || s.idx < IW'(SIZE_CHARS_MAX)) ? PM_DONE : PM_BAD;
         end else if (s.idx >= IW'(SIZE_CHARS_MAX)) begin
            r.mode = PM_BAD;
         end else if (s.mode == PM_ZERO && (c == "x" || c == "X")) begin
            r.mode = PM_HEX;
            step   = 1'b1;
         end else if (s.mode == PM_HEX) begin
            step = 1'b1;
            if (c >= "0" && c <= "9") begin
               d = 4'(c - "0");
            end else if (c >= "a" && c <= "f") begin
               d = 4'(c - "a" + 8'd10);
            end else if (c >= "A" && c <= "F") begin
               d = 4'(c - "A" + 8'd10);
            end else begin
               r.mode = PM_BAD;
               step   = 1'b0;
            end
            if (step) begin
               r.acc = {s.acc[27:0], d};
            end
         end else if (s.idx != '0 && (c == "k" || c == "K")) begin
            r.acc  = {s.acc[21:0], 10'd0};
            r.mode = PM_DONE;
            step   = 1'b1;
         end else if (s.idx != '0 && (c == "m" || c == "M")) begin
            r.acc  = {s.acc[11:0], 20'd0};
            r.mode = PM_DONE;
            step   = 1'b1;
         end else if (c >= "0" && c <= "9") begin
            r.acc  = {s.acc[28:0], 3'd0} + {s.acc[30:0], 1'b0} + {28'd0, 4'(c - "0")};
            r.mode = (s.idx == '0 && c == "0") ? PM_ZERO : PM_DEC;
            step   = 1'b1;
         end else begin
            r.mode = PM_BAD;
         end
         if (step) begin
            r.idx = s.idx + 1'b1;
         end
      end
      return r;
   endfunction

   logic [31:0] size_limit_ff,  size_limit_in;
   logic [7:0]  error_limit_ff, error_limit_in;
   phase_type   phase_ff,       phase_in;
   logic [10:0] count_ff,       count_in;
   kind_type    kind_ff,        kind_in;
   logic [7:0]  second_ff,      second_in;
   logic [7:0]  block_ff,       block_in;
   logic        comp_ok_ff,     comp_ok_in;
   logic [15:0] crc_ff,         crc_in;
   logic [15:0] crc_rx_ff,      crc_rx_in;
   logic [7:0]  expected_ff,    expected_in;
   logic [7:0]  errors_ff,      errors_in;
   logic        started_ff,     started_in;
   field_type   field_ff,       field_in;
   parse_type   parse_ff,       parse_in;
   logic        empty_ff,       empty_in;
   logic [31:0] size_ff,        size_in;
   logic        size_valid_ff,  size_valid_in;

   logic [1:0]  n_out;
   logic [7:0]  r0, r1;
   logic        clear;
   logic [7:0]  b;
   logic [10:0] plen;
   logic [10:0] pos;
   logic [7:0]  err_next;
   parse_type   fin;
   logic [31:0] fsize;

   always_comb begin
      size_limit_in  = size_limit_ff;
      error_limit_in = error_limit_ff;
      phase_in       = phase_ff;
      count_in       = count_ff;
      kind_in        = kind_ff;
      second_in      = second_ff;
      block_in       = block_ff;
      comp_ok_in     = comp_ok_ff;
      crc_in         = crc_ff;
      crc_rx_in      = crc_rx_ff;
      expected_in    = expected_ff;
      errors_in      = errors_ff;
      started_in     = started_ff;
      field_in       = field_ff;
      parse_in       = parse_ff;
      empty_in       = empty_ff;
      size_in        = size_ff;
      size_valid_in  = size_valid_ff;
      n_out          = 2'd0;
      r0             = 8'd0;
      r1             = 8'd0;
      clear          = 1'b0;
      b              = req.rx_byte;
      plen           = (kind_ff == K_SOH) ? SHORT_LEN : LONG_LEN;
      pos            = count_ff - 11'd3;
      err_next       = (started_ff && errors_ff != 8'hff) ? errors_ff + 8'd1 : errors_ff;
      fin            = size_feed(parse_ff, 8'h00);
      fsize          = (fin.mode == PM_DONE) ? fin.acc : 32'd0;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SIZE_LIMIT:  size_limit_in  = csr_write_data;
            CSR_ERROR_LIMIT: error_limit_in = csr_write_data[7:0];
            default: ;
         endcase
      end

      if (accept && phase_ff == ST_RUNNING) begin
         if (req.cmd) begin
            // Window closed: judge whatever short frame is pending.
            clear = 1'b1;
            if (kind_ff == K_EOT) begin
               errors_in   = 8'd0;
               expected_in = 8'd0;
               r0          = BYTE_ACK;
               n_out       = 2'd1;
            end else if (kind_ff == K_CA && count_ff >= 11'd2 && second_ff == BYTE_CA) begin
               errors_in = 8'd0;
               phase_in  = ST_ABORTED;
               r0        = BYTE_ACK;
               n_out     = 2'd1;
            end else if (kind_ff == K_ABT) begin
               phase_in = ST_ABORTED;
               r0       = BYTE_CA;
               r1       = BYTE_CA;
               n_out    = 2'd2;
            end else begin
               errors_in = err_next;
               if (err_next > error_limit_ff) begin
                  phase_in = ST_ABORTED;
                  r0       = BYTE_CA;
                  r1       = BYTE_CA;
                  n_out    = 2'd2;
               end else begin
                  r0    = BYTE_C;
                  n_out = 2'd1;
               end
            end
         end else if (count_ff == 11'd0) begin
            priority if (b == BYTE_SOH)           kind_in = K_SOH;
            else if (b == BYTE_STX)               kind_in = K_STX;
            else if (b == BYTE_EOT)               kind_in = K_EOT;
            else if (b == BYTE_CA)                kind_in = K_CA;
            else if (b == "A" || b == "a")        kind_in = K_ABT;
            else                                  kind_in = K_OTHER;
            count_in = 11'd1;
         end else if (kind_ff == K_SOH || kind_ff == K_STX) begin
            if (count_ff == 11'd1) begin
               block_in  = b;
               second_in = b;
            end else if (count_ff == 11'd2) begin
               comp_ok_in = (b == ~block_ff);
            end else if (count_ff < plen + 11'd3) begin
               crc_in = crc16_byte(crc_ff, b);
               if (field_ff == HF_NAME) begin
                  if (b == 8'h00) begin
                     if (pos == 11'd0) begin
                        empty_in = 1'b1;
                     end
                     field_in = HF_SIZE;
                  end
               end else if (field_ff == HF_SIZE) begin
                  parse_in = size_feed(parse_ff, b);
                  if (b == 8'h20 || b == 8'h00) begin
                     field_in = HF_REST;
                  end
               end
            end else if (count_ff == plen + 11'd3) begin
               crc_rx_in = {b, 8'h00};
            end else begin
               crc_rx_in = {crc_rx_ff[15:8], b};
            end
            count_in = count_ff + 11'd1;
            if (count_ff + 11'd1 >= plen + 11'd5) begin
               // Last CRC byte: judge the full frame.
               clear = 1'b1;
               if (!comp_ok_ff || crc_ff != {crc_rx_ff[15:8], b}) begin
                  errors_in = err_next;
                  if (err_next > error_limit_ff) begin
                     phase_in = ST_ABORTED;
                     r0       = BYTE_CA;
                     r1       = BYTE_CA;
                     n_out    = 2'd2;
                  end else begin
                     r0    = BYTE_C;
                     n_out = 2'd1;
                  end
               end else begin
                  errors_in = 8'd0;
                  if (block_ff != expected_ff) begin
                     r0    = BYTE_NAK;
                     n_out = 2'd1;
                  end else if (expected_ff == 8'd0) begin
                     if (empty_ff) begin
                        phase_in = ST_DONE;
                        r0       = BYTE_ACK;
                        n_out    = 2'd1;
                     end else begin
                        size_in       = fsize;
                        size_valid_in = 1'b1;
                        expected_in   = expected_ff + 8'd1;
                        started_in    = 1'b1;
                        n_out         = 2'd2;
                        if (fsize > size_limit_ff) begin
                           phase_in = ST_OVERSIZE;
                           r0       = BYTE_CA;
                           r1       = BYTE_CA;
                        end else begin
                           r0 = BYTE_ACK;
                           r1 = BYTE_C;
                        end
                     end
                  end else begin
                     expected_in = expected_ff + 8'd1;
                     started_in  = 1'b1;
                     r0          = BYTE_ACK;
                     n_out       = 2'd1;
                  end
               end
            end
         end else begin
            if (count_ff == 11'd1) begin
               second_in = b;
            end
            if (count_ff < COUNT_MAX) begin
               count_in = count_ff + 11'd1;
            end
         end
      end

      if (clear) begin
         count_in   = 11'd0;
         kind_in    = K_NONE;
         second_in  = 8'd0;
         block_in   = 8'd0;
         comp_ok_in = 1'b0;
         crc_in     = 16'd0;
         crc_rx_in  = 16'd0;
         field_in   = HF_NAME;
         parse_in   = '{mode: PM_START, idx: '0, acc: 32'd0};
         empty_in   = 1'b0;
      end

      push.count                = n_out;
      push.first.reply_byte     = r0;
      push.first.last_of_run    = (n_out == 2'd1);
      push.first.session_status = phase_in;
      push.first.size_bytes     = size_in;
      push.first.size_known     = size_valid_in;
      push.second.reply_byte     = r1;
      push.second.last_of_run    = 1'b1;
      push.second.session_status = phase_in;
      push.second.size_bytes     = size_in;
      push.second.size_known     = size_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_limit_ff  <= 32'd98304;
         error_limit_ff <= 8'd5;
         phase_ff       <= ST_RUNNING;
         count_ff       <= 11'd0;
         kind_ff        <= K_NONE;
         second_ff      <= 8'd0;
         block_ff       <= 8'd0;
         comp_ok_ff     <= 1'b0;
         crc_ff         <= 16'd0;
         crc_rx_ff      <= 16'd0;
         expected_ff    <= 8'd0;
         errors_ff      <= 8'd0;
         started_ff     <= 1'b0;
         field_ff       <= HF_NAME;
         parse_ff       <= '{mode: PM_START, idx: '0, acc: 32'd0};
         empty_ff       <= 1'b0;
         size_ff        <= 32'd0;
         size_valid_ff  <= 1'b0;
      end else begin
         size_limit_ff  <= size_limit_in;
         error_limit_ff <= error_limit_in;
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         kind_ff        <= kind_in;
         second_ff      <= second_in;
         block_ff       <= block_in;
         comp_ok_ff     <= comp_ok_in;
         crc_ff         <= crc_in;
         crc_rx_ff      <= crc_rx_in;
         expected_ff    <= expected_in;
         errors_ff      <= errors_in;
         started_ff     <= started_in;
         field_ff       <= field_in;
         parse_ff       <= parse_in;
         empty_ff       <= empty_in;
         size_ff        <= size_in;
         size_valid_ff  <= size_valid_in;
      end
   end

`include "ymodem_receiver_assert.svh"
   `YMR_ASSERT(a_no_reply_after_end, (phase_ff != ST_RUNNING) |-> (push.count == 2'd0))
   `YMR_ASSERT(a_push_count_range, push.count != 2'd3)
   `YMR_ASSERT(a_errors_need_session, (!started_ff) |-> (errors_ff == 8'd0))
   `YMR_ASSERT(a_block_needs_session, (expected_ff != 8'd0) |-> started_ff)

endmodule

[rtl/ymr_rsp_fifo.sv]
module ymr_rsp_fifo
   import ymr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     rsp_valid,
   output rsp_type  rsp_payload,
   output logic     no_room
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   rsp_type          entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff,  count_in;
   logic [AW-1:0]    wr_next;

   always_comb begin
      wr_next   = wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff + AW'(push.count);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.second;
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entries_ff[rd_ptr_ff];
   // Keep room for the two beats one item may produce.
   assign no_room     = (count_ff > CW'(DEPTH - 2));

endmodule

[rtl/ymodem_receiver.sv]
// YMODEM receive controller with CRC-16 checking.
// The req_ channel carries one beat per received serial byte (cmd low) or
// per closed receive window (cmd high). The rsp_ channel returns the reply
// bytes to send back: ACK, NAK, 'C' or a pair of CA bytes, each beat also
// carrying the session status, the parsed file size and its known flag.
// An input beat yields zero, one or two beats on rsp_ from the cycle after
// acceptance, one per cycle while rsp_stall is low. Input beats can be
// taken every cycle, limited only by the four-entry queue: req_stall rises
// while fewer than two entries are free, so rsp_stall holds back the input
// side. The csr_ port writes size_limit (index 0) and error_limit (index
// 1); the user must do so only while idle, as the block does not enforce
// it. Synchronous reset returns the session to running, empties the queue
// and restores the limits to 98304 bytes and five errors. Once ended, the
// session accepts beats but gives no replies until reset.
module ymodem_receiver
   import ymr_pkg::*;
#(
   parameter int SIZE_CHARS_MAX = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);

   push_type push;
   logic     accept;
   logic     no_room;

   assign req_stall = no_room;
   assign accept    = req_valid && !no_room;

   ymr_core #(
      .SIZE_CHARS_MAX(SIZE_CHARS_MAX)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req              (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push             (push)
   );

   // The queue decouples reply beats from the input rate.
   ymr_rsp_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .pop         (rsp_valid && !rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .no_room     (no_room)
   );

endmodule
